>>> src/rmsea_pkg.sv
// ----------------------------------------------------------------------------
// rmsea_pkg - shared types and microcode for the rmse accumulator
// Payload structs, datapath control word and the sequencer program table.
// ----------------------------------------------------------------------------
package rmsea_pkg;

   // field and datapath widths
   localparam int COUNT_BITS_DEFAULT = 24;
   localparam int SAMPLE_W           = 16;
   localparam int RMSE_W             = 24;
   localparam int PAIR_COUNT_W       = 24;
   localparam int SUM_W              = 58;
   localparam int FRAC_SHIFT         = 16;
   localparam int NUM_W              = SUM_W + FRAC_SHIFT;
   localparam int QUOT_W             = 48;
   localparam int ROOT_W             = QUOT_W / 2;
   localparam int ROOT_REM_W         = ROOT_W + 1;
   localparam int DIV_STEPS          = NUM_W;
   localparam int SQRT_STEPS         = ROOT_W;
   localparam int LOOP_W             = $clog2(DIV_STEPS);

   // input transaction payload
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_a;
      logic signed [SAMPLE_W-1:0] sample_b;
      logic                       last;
   } req_payload_type;

   // result transaction payload
   typedef struct packed {
      logic [RMSE_W-1:0]       rmse;
      logic [PAIR_COUNT_W-1:0] pair_count;
      logic                    overflowed;
   } rsp_payload_type;

   // program steps
   typedef enum logic [2:0] {
      STEP_ACCUM     = 3'd0,
      STEP_DIV_LOAD  = 3'd1,
      STEP_DIV_ITER  = 3'd2,
      STEP_SQRT_LOAD = 3'd3,
      STEP_SQRT_ITER = 3'd4,
      STEP_EMIT      = 3'd5
   } step_type;

   // branch conditions: advance to target when true, otherwise hold
   typedef enum logic [1:0] {
      COND_ALWAYS,
      COND_LAST_TAKEN,
      COND_LOOP_DONE,
      COND_SLOT_FREE
   } cond_type;

   // one microcode word
   typedef struct packed {
      logic              accept;
      logic              div_load;
      logic              div_step;
      logic              sqrt_load;
      logic              sqrt_step;
      logic              emit;
      logic              loop_load;
      logic [LOOP_W-1:0] loop_init;
      cond_type          cond;
      step_type          target;
   } ucode_type;

   // qualified strobes into the datapath
   typedef struct packed {
      logic              acc_en;
      logic              div_load;
      logic              div_step;
      logic              sqrt_load;
      logic              sqrt_step;
      logic              clear;
      logic              loop_load;
      logic [LOOP_W-1:0] loop_init;
   } dp_ctrl_type;

   // program table
   function automatic ucode_type ucode_rom(input step_type step);
      ucode_type w;
      w = '0;
      w.cond   = COND_ALWAYS;
      w.target = STEP_ACCUM;
      case (step)
         STEP_ACCUM: begin
            w.accept = 1'b1;
            w.cond   = COND_LAST_TAKEN;
            w.target = STEP_DIV_LOAD;
         end
         STEP_DIV_LOAD: begin
            w.div_load  = 1'b1;
            w.loop_load = 1'b1;
            w.loop_init = LOOP_W'(DIV_STEPS - 1);
            w.target    = STEP_DIV_ITER;
         end
         STEP_DIV_ITER: begin
            w.div_step = 1'b1;
            w.cond     = COND_LOOP_DONE;
            w.target   = STEP_SQRT_LOAD;
         end
         STEP_SQRT_LOAD: begin
            w.sqrt_load = 1'b1;
            w.loop_load = 1'b1;
            w.loop_init = LOOP_W'(SQRT_STEPS - 1);
            w.target    = STEP_SQRT_ITER;
         end
         STEP_SQRT_ITER: begin
            w.sqrt_step = 1'b1;
            w.cond      = COND_LOOP_DONE;
            w.target    = STEP_EMIT;
         end
         STEP_EMIT: begin
            w.emit   = 1'b1;
            w.cond   = COND_SLOT_FREE;
            w.target = STEP_ACCUM;
         end
         default: begin
            w.target = STEP_ACCUM;
         end
      endcase
      return w;
   endfunction

endpackage

>>> src/rmsea_datapath.sv
// ----------------------------------------------------------------------------
// rmsea_datapath - accumulators, restoring divider and square root
// Plain datapath driven one strobe set per cycle by the sequencer.
// ----------------------------------------------------------------------------
module rmsea_datapath #(
   parameter int COUNT_BITS = rmsea_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  rmsea_pkg::dp_ctrl_type   ctrl,
   input  rmsea_pkg::req_payload_type req_payload,
   output logic                     loop_done,
   output rmsea_pkg::rsp_payload_type result
);
   import rmsea_pkg::*;

   // accumulator state
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [COUNT_BITS-1:0] pairs_ff, pairs_in;
   logic                  sat_ff, sat_in;

   // shared loop counter
   logic [LOOP_W-1:0] loop_ff, loop_in;

   // divider registers
   logic [NUM_W-1:0]      num_ff, num_in;
   logic [COUNT_BITS-1:0] drem_ff, drem_in;
   logic [QUOT_W-1:0]     quot_ff, quot_in;
   logic                  big_ff, big_in;

   // square root registers
   logic [QUOT_W-1:0]     rad_ff, rad_in;
   logic [ROOT_REM_W-1:0] srem_ff, srem_in;
   logic [ROOT_W-1:0]     root_ff, root_in;

   // combinational terms
   logic signed [SAMPLE_W:0]     diff;
   logic [SAMPLE_W:0]            mag;
   logic [2*SAMPLE_W+1:0]        sq;
   logic [SUM_W:0]               sum_ext;
   logic [COUNT_BITS:0]          dshift;
   logic                         dge;
   logic [COUNT_BITS:0]          dsub;
   logic [ROOT_REM_W+1:0]        sshift;
   logic [ROOT_REM_W+1:0]        trial;
   logic                         sge;
   logic [ROOT_REM_W+1:0]        ssub;

   // squared difference and saturating sum
   always_comb begin
      diff    = (SAMPLE_W+1)'(req_payload.sample_a) - (SAMPLE_W+1)'(req_payload.sample_b);
      mag     = diff[SAMPLE_W] ? (SAMPLE_W+1)'(-diff) : (SAMPLE_W+1)'(diff);
      sq      = (2*SAMPLE_W+2)'(mag) * (2*SAMPLE_W+2)'(mag);
      sum_ext = {1'b0, sum_ff} + (SUM_W+1)'(sq);
   end

   // one restoring divide step
   always_comb begin
      dshift = {drem_ff, num_ff[NUM_W-1]};
      dge    = dshift >= {1'b0, pairs_ff};
      dsub   = dshift - {1'b0, pairs_ff};
   end

   // one digit-by-digit root step
   always_comb begin
      sshift = {srem_ff, rad_ff[QUOT_W-1:QUOT_W-2]};
      trial  = (ROOT_REM_W+2)'({root_ff, 2'b01});
      sge    = sshift >= trial;
      ssub   = sshift - trial;
   end

   assign loop_done = (loop_ff == '0);

   // next state
   always_comb begin
      sum_in   = sum_ff;
      pairs_in = pairs_ff;
      sat_in   = sat_ff;
      loop_in  = loop_ff;
      num_in   = num_ff;
      drem_in  = drem_ff;
      quot_in  = quot_ff;
      big_in   = big_ff;
      rad_in   = rad_ff;
      srem_in  = srem_ff;
      root_in  = root_ff;

      if (ctrl.acc_en) begin
         sum_in = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
         if (&pairs_ff) begin
            sat_in = 1'b1;
         end else begin
            pairs_in = pairs_ff + 1'b1;
         end
      end
      if (ctrl.clear) begin
         sum_in   = '0;
         pairs_in = '0;
         sat_in   = 1'b0;
      end

      if (ctrl.loop_load) begin
         loop_in = ctrl.loop_init;
      end else if ((ctrl.div_step || ctrl.sqrt_step) && !loop_done) begin
         loop_in = loop_ff - 1'b1;
      end

      if (ctrl.div_load) begin
         num_in  = {sum_ff, {FRAC_SHIFT{1'b0}}};
         drem_in = '0;
         quot_in = '0;
         big_in  = 1'b0;
      end else if (ctrl.div_step) begin
         num_in  = {num_ff[NUM_W-2:0], 1'b0};
         drem_in = dge ? dsub[COUNT_BITS-1:0] : dshift[COUNT_BITS-1:0];
         quot_in = {quot_ff[QUOT_W-2:0], dge};
         // quotient bits at or above the root input width flag overflow
         if (dge && (32'(loop_ff) >= QUOT_W)) begin
            big_in = 1'b1;
         end
      end

      if (ctrl.sqrt_load) begin
         rad_in  = quot_ff;
         srem_in = '0;
         root_in = '0;
      end else if (ctrl.sqrt_step) begin
         rad_in  = {rad_ff[QUOT_W-3:0], 2'b00};
         srem_in = sge ? ssub[ROOT_REM_W-1:0] : sshift[ROOT_REM_W-1:0];
         root_in = {root_ff[ROOT_W-2:0], sge};
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         pairs_ff <= '0;
         sat_ff   <= 1'b0;
         loop_ff  <= '0;
      end else begin
         sum_ff   <= sum_in;
         pairs_ff <= pairs_in;
         sat_ff   <= sat_in;
         loop_ff  <= loop_in;
      end
   end

   // arithmetic working registers
   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      drem_ff <= drem_in;
      quot_ff <= quot_in;
      big_ff  <= big_in;
      rad_ff  <= rad_in;
      srem_ff <= srem_in;
      root_ff <= root_in;
   end

   // result fields
   always_comb begin
      result.rmse       = big_ff ? {RMSE_W{1'b1}} : RMSE_W'(root_ff);
      result.pair_count = PAIR_COUNT_W'(pairs_ff);
      result.overflowed = sat_ff;
   end

endmodule

>>> src/rmse_accumulator_unit.sv
// ----------------------------------------------------------------------------
// rmse_accumulator_unit - streaming root mean square error
// Sums squared sample differences per set; on the last pair it divides by
// the pair count and takes the square root under microcode control.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake            payload
//  req_     in         req_valid/req_ready  sample_a, sample_b, last
//  rsp_     out        rsp_valid/rsp_ready  rmse, pair_count, overflowed
//
//  a pair without last is taken every cycle while the program sits at accumulate
//  a last pair runs divide load, divide steps, root load, root steps and the emit
//  step before the next pair is taken; the shared loop counter counts the steps
//  the result sits in an output register, so new pairs are taken while it waits
//  reset clears accumulators, sequencer and output valid; no clearing pass
//
module rmse_accumulator_unit #(
   parameter int COUNT_BITS = rmsea_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  rmsea_pkg::req_payload_type req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output rmsea_pkg::rsp_payload_type rsp_payload
);
   import rmsea_pkg::*;

   step_type        step_ff, step_in;
   ucode_type       word;
   dp_ctrl_type     dp_ctrl;
   logic            loop_done;
   logic            slot_free;
   logic            req_fire;
   logic            emit_fire;
   logic            cond_true;
   rsp_payload_type result;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;
   logic            rsp_valid_ff, rsp_valid_in;

   // fetch and sequence
   always_comb begin
      word      = ucode_rom(step_ff);
      slot_free = !rsp_valid_ff || rsp_ready;
      req_ready = word.accept;
      req_fire  = word.accept && req_valid;
      emit_fire = word.emit && slot_free;
      case (word.cond)
         COND_ALWAYS:     cond_true = 1'b1;
         COND_LAST_TAKEN: cond_true = req_fire && req_payload.last;
         COND_LOOP_DONE:  cond_true = loop_done;
         COND_SLOT_FREE:  cond_true = slot_free;
         default:         cond_true = 1'b0;
      endcase
      step_in = cond_true ? word.target : step_ff;

      dp_ctrl.acc_en    = req_fire;
      dp_ctrl.div_load  = word.div_load;
      dp_ctrl.div_step  = word.div_step;
      dp_ctrl.sqrt_load = word.sqrt_load;
      dp_ctrl.sqrt_step = word.sqrt_step;
      dp_ctrl.clear     = emit_fire;
      dp_ctrl.loop_load = word.loop_load;
      dp_ctrl.loop_init = word.loop_init;
   end

   // step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_ACCUM;
      end else begin
         step_ff <= step_in;
      end
   end

   rmsea_datapath #(
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (dp_ctrl),
      .req_payload (req_payload),
      .loop_done   (loop_done),
      .result      (result)
   );

   // output register
   always_comb begin
      rsp_payload_in = rsp_payload_ff;
      rsp_valid_in   = rsp_valid_ff;
      if (emit_fire) begin
         rsp_payload_in = result;
         rsp_valid_in   = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule
